[src/spbaw_pkg.sv]
// Shared types, widths, register indexes and helper functions of the speed PI controller.
package spbaw_pkg;

  localparam int GAIN_W = 32;   // Q8.24 gains
  localparam int ACC_W  = 48;   // saturated working width, Q31.16
  localparam int MAG_W  = 56;   // rounded product magnitude
  localparam int WIDE_W = 60;   // headroom before saturation
  localparam int DVD_W  = 58;   // dividend of the divide by 1000

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [2:0] REG_BACKCALC_GAIN = 3'd2;
  localparam logic [2:0] REG_OUT_UPPER     = 3'd3;
  localparam logic [2:0] REG_OUT_LOWER     = 3'd4;
  localparam logic [2:0] REG_RAMP_STEP     = 3'd5;

  // Rounding point of a product: Q8.24 gains or the Q3.29 two-pi constant.
  typedef enum logic {
    RND_Q24,
    RND_Q29
  } rnd_sel_t;

  // Result of the serial multiplier: rounded magnitude and its sign.
  typedef struct packed {
    logic             done;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } mul_res_t;

  // Result of the serial divider.
  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_res_t;

  // Saturate a wide signed value to 48 bits.
  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-ACC_W:0] top;
    top = v[WIDE_W-1:ACC_W-1];
    if (top == '0 || top == '1) begin
      return v[ACC_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

  // Turn a sign and a magnitude into a two's complement value.
  function automatic logic signed [MAG_W:0] signed_mag(input logic neg,
                                                       input logic [MAG_W-1:0] m);
    logic signed [MAG_W:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

endpackage

[src/spbaw_mul.sv]
// Radix-4 serial multiplier: 48 bit signed operand times 32 bit gain, rounded to Q16.
module spbaw_mul import spbaw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] opnd,
  input  logic [GAIN_W-1:0]       gain,
  input  rnd_sel_t                sel,
  output mul_res_t                res
);

  localparam int STEPS  = GAIN_W / 2;
  localparam int CNT_W  = $clog2(STEPS);
  localparam int HI_W   = ACC_W + 2;
  localparam int PROD_W = HI_W + GAIN_W;
  localparam logic [PROD_W-1:0] HALF_Q29 = PROD_W'(1) << 28;
  localparam logic [PROD_W-1:0] HALF_Q24 = PROD_W'(1) << 23;

  typedef enum logic [2:0] {
    M_IDLE,
    M_MAG,
    M_TRIPLE,
    M_STEP,
    M_ROUND
  } mstate_t;

  mstate_t                 state;
  logic signed [ACC_W-1:0] opnd_r;
  logic [ACC_W-1:0]        a;
  logic [HI_W-1:0]         a3;
  logic [HI_W-1:0]         hi;
  logic [GAIN_W-1:0]       lo;
  logic [CNT_W-1:0]        cnt;
  logic                    neg;
  rnd_sel_t                sel_r;
  logic [MAG_W-1:0]        mag;
  logic                    done;

  logic [HI_W-1:0]   addend;
  logic [HI_W:0]     step_sum;
  logic [PROD_W-1:0] rsum;

  // One radix-4 digit of the gain per cycle, taken from the low end.
  always_comb begin
    case (lo[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, a};
      2'd2:    addend = {1'b0, a, 1'b0};
      default: addend = a3;
    endcase
    step_sum = {1'b0, hi} + {1'b0, addend};
    rsum = {hi, lo} + ((sel_r == RND_Q29) ? HALF_Q29 : HALF_Q24);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            opnd_r <= opnd;
            lo     <= gain;
            sel_r  <= sel;
            state  <= M_MAG;
          end
        end
        M_MAG: begin
          neg   <= opnd_r[ACC_W-1];
          a     <= opnd_r[ACC_W-1] ? ACC_W'(-opnd_r) : ACC_W'(opnd_r);
          state <= M_TRIPLE;
        end
        M_TRIPLE: begin
          a3    <= {2'b00, a} + {1'b0, a, 1'b0};
          hi    <= '0;
          cnt   <= '0;
          state <= M_STEP;
        end
        M_STEP: begin
          hi  <= {1'b0, step_sum[HI_W:2]};
          lo  <= {step_sum[1:0], lo[GAIN_W-1:2]};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(STEPS - 1)) begin
            state <= M_ROUND;
          end
        end
        M_ROUND: begin
          if (sel_r == RND_Q29) begin
            mag <= MAG_W'(rsum[PROD_W-1:29]);
          end else begin
            mag <= rsum[MAG_W+23:24];
          end
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign res = {done, neg, mag};

endmodule

[src/spbaw_div.sv]
// Radix-4 serial divider of a 58 bit unsigned value by the constant 1000.
module spbaw_div import spbaw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  output div_res_t         res
);

  localparam int STEPS = DVD_W / 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [11:0] DIV_1X = 12'd1000;
  localparam logic [11:0] DIV_2X = 12'd2000;
  localparam logic [11:0] DIV_3X = 12'd3000;

  typedef enum logic {
    D_IDLE,
    D_RUN
  } dstate_t;

  dstate_t          state;
  logic [DVD_W-1:0] dvd;
  logic [9:0]       rem;
  logic [CNT_W-1:0] cnt;
  logic             done;

  logic [11:0] trial;
  logic [1:0]  digit;
  logic [9:0]  rem_next;

  // The remainder stays below 1000, so one quotient digit needs three compares.
  always_comb begin
    trial = {rem, dvd[DVD_W-1:DVD_W-2]};
    if (trial >= DIV_3X) begin
      digit    = 2'd3;
      rem_next = 10'(trial - DIV_3X);
    end else if (trial >= DIV_2X) begin
      digit    = 2'd2;
      rem_next = 10'(trial - DIV_2X);
    end else if (trial >= DIV_1X) begin
      digit    = 2'd1;
      rem_next = 10'(trial - DIV_1X);
    end else begin
      digit    = 2'd0;
      rem_next = trial[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            dvd   <= dividend;
            rem   <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          dvd <= {dvd[DVD_W-3:0], digit};
          rem <= rem_next;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(STEPS - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign res = {done, dvd};

endmodule

[src/speed_pi_backcalc_antiwindup.sv]
// Top level of the speed PI controller with back-calculation anti-windup.
//
// Each input word carries a speed reference in Hz and a measured speed in rad/s, both
// signed Q15.16, and gives exactly one output word with the clamped controller output,
// the ramped reference, the clamp state and the direction-reversal counter. The block
// works on one word at a time: three products go through one shared radix-4 serial
// multiplier (two bits of the gain per cycle plus setup and rounding), the integral
// product runs on a second multiplier beside the proportional one, and the final scaling
// by 0.001 is a radix-4 serial divide by 1000. A new input word is taken in the cycle
// after the result has moved into the output register, so a waiting result does not hold
// off the next word unless it is still waiting when the next result is ready. The ramp,
// the reversal counter and the integral are updated once per word; the ramp is reported
// only and does not enter the error. Gains are unsigned Q8.24, each product is rounded to
// Q16 half away from zero, and the error, sums and integral saturate to 48 bits.
module speed_pi_backcalc_antiwindup import spbaw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] ref_speed, [63:32] feedback_speed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // [31:0] drive_out, [63:32] ramped_ref,
                                      // [65:64] clamp_state, [81:66] reversal_count
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [GAIN_W-1:0] TWO_PI_Q29   = 32'd3373259426;
  localparam logic signed [31:0] REV_REF    = 32'sd65536;      // 1.0
  localparam logic signed [31:0] REV_FDB    = 32'sd26214400;   // 400.0
  localparam logic signed [31:0] CTRL_FDB   = 32'sd32768000;   // 500.0
  localparam logic signed [32:0] RAMP_SNAP  = 33'sd32768;      // 0.5
  localparam logic [22:0]        PENALTY_STEP = 23'd100;
  localparam logic [DVD_W-1:0]   DIV_HALF   = 58'd500;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_W_REF,
    ST_ERR,
    ST_SUM,
    ST_W_P,
    ST_CLAMP,
    ST_DIFF,
    ST_W_B,
    ST_DELTA,
    ST_MAGD,
    ST_DIVS,
    ST_W_DIV,
    ST_INTEG,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PEN_NONE,
    PEN_SUB,
    PEN_ADD
  } pen_sel_t;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_HIGH = 2'd1,
    CLAMP_LOW  = 2'd2
  } clamp_t;

  state_t state;

  // Configuration registers.
  logic [GAIN_W-1:0] prop_gain;
  logic [GAIN_W-1:0] integ_gain;
  logic [GAIN_W-1:0] backcalc_gain;
  logic signed [31:0] out_upper;
  logic signed [31:0] out_lower;
  logic [30:0]        ramp_step;

  // Controller state.
  logic signed [ACC_W-1:0] integral;
  logic signed [31:0]      ramp_value;
  logic [15:0]             rev_ticks;

  // Per-word working registers.
  logic signed [31:0]      fdb_r;
  logic [15:0]             pen_cnt;
  pen_sel_t                pen_sel;
  logic signed [ACC_W-1:0] pen_fdb;
  logic signed [ACC_W-1:0] err;
  logic signed [MAG_W:0]   temp_r;
  logic signed [MAG_W:0]   integ_term;
  logic signed [31:0]      outv;
  clamp_t                  clamp_state;
  logic signed [DVD_W-1:0] delta;
  logic                    dneg;
  logic [DVD_W-1:0]        dmag;

  // Input word fields.
  logic signed [31:0] ref_in;
  logic signed [31:0] fdb_in;
  logic               accept;

  assign ref_in        = s_axis_tdata[31:0];
  assign fdb_in        = s_axis_tdata[63:32];
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Reference ramp: one step toward the target, snapping when within half a unit.
  logic signed [32:0] ramp_d;
  logic signed [33:0] ramp_up;
  logic signed [33:0] ramp_dn;
  logic signed [33:0] ramp_sel;
  logic signed [31:0] ramp_next;

  always_comb begin
    ramp_d   = 33'(ref_in) - 33'(ramp_value);
    ramp_up  = 34'(ramp_value) + $signed({3'b000, ramp_step});
    ramp_dn  = 34'(ramp_value) - $signed({3'b000, ramp_step});
    ramp_sel = (ramp_d > 33'sd0) ? ramp_up : ramp_dn;
    if (ramp_sel > 34'sd2147483647) begin
      ramp_next = 32'sh7FFFFFFF;
    end else if (ramp_sel < -34'sd2147483648) begin
      ramp_next = 32'sh80000000;
    end else begin
      ramp_next = ramp_sel[31:0];
    end
    if (ramp_d < RAMP_SNAP && ramp_d > -RAMP_SNAP) begin
      ramp_next = ref_in;
    end
  end

  // Direction reversal: the counter used for this word's penalty is kept apart from
  // the stored counter, which a feedback magnitude above 500 clears afterwards.
  logic        rev_fwd;
  logic        rev_bwd;
  logic        fdb_over;
  logic [15:0] cnt_inc;
  logic [15:0] pen_cnt_next;
  logic [15:0] rev_ticks_next;

  always_comb begin
    rev_fwd        = (ref_in > REV_REF) && (fdb_in < -REV_FDB);
    rev_bwd        = (ref_in < -REV_REF) && (fdb_in > REV_FDB);
    fdb_over       = (fdb_in > CTRL_FDB) || (fdb_in < -CTRL_FDB);
    cnt_inc        = (rev_ticks == 16'hFFFF) ? rev_ticks : rev_ticks + 16'd1;
    pen_cnt_next   = (rev_fwd || rev_bwd) ? cnt_inc : 16'd0;
    rev_ticks_next = fdb_over ? 16'd0 : pen_cnt_next;
  end

  // Penalty of 100 per counted tick in Q16, combined with the feedback term.
  logic [22:0]             pen_units;
  logic signed [ACC_W-1:0] pen_q16;
  logic signed [ACC_W-1:0] pen_val;

  always_comb begin
    pen_units = pen_cnt * PENALTY_STEP;
    pen_q16   = $signed({9'd0, pen_units, 16'd0});
    case (pen_sel)
      PEN_SUB: pen_val = -pen_q16;
      PEN_ADD: pen_val = pen_q16;
      default: pen_val = '0;
    endcase
  end

  // Operand selection of the two multipliers and the divider.
  mul_res_t                mul0_res;
  mul_res_t                mul1_res;
  div_res_t                div_res;
  logic                    mul0_start;
  logic signed [ACC_W-1:0] mul0_opnd;
  logic [GAIN_W-1:0]       mul0_gain;
  rnd_sel_t                mul0_sel;
  logic                    mul1_start;
  logic                    div_start;

  always_comb begin
    mul0_start = 1'b0;
    mul0_opnd  = err;
    mul0_gain  = prop_gain;
    mul0_sel   = RND_Q24;
    unique case (state)
      ST_IDLE: begin
        mul0_start = accept;
        mul0_opnd  = ACC_W'(ref_in);
        mul0_gain  = TWO_PI_Q29;
        mul0_sel   = RND_Q29;
      end
      ST_SUM: begin
        mul0_start = 1'b1;
        mul0_opnd  = sat48(WIDE_W'(err) + WIDE_W'(integral));
        mul0_gain  = prop_gain;
      end
      ST_DIFF: begin
        mul0_start = 1'b1;
        mul0_opnd  = sat48(WIDE_W'(outv) - WIDE_W'(temp_r));
        mul0_gain  = backcalc_gain;
      end
      default: ;
    endcase
    mul1_start = (state == ST_SUM);
    div_start  = (state == ST_DIVS);
  end

  // Shared multiplier: two-pi times reference, proportional path, back-calculation.
  spbaw_mul u_mul0 (
    .clk   (clk),
    .rst   (rst),
    .start (mul0_start),
    .opnd  (mul0_opnd),
    .gain  (mul0_gain),
    .sel   (mul0_sel),
    .res   (mul0_res)
  );

  // Integral gain times error, run beside the proportional product.
  spbaw_mul u_mul1 (
    .clk   (clk),
    .rst   (rst),
    .start (mul1_start),
    .opnd  (err),
    .gain  (integ_gain),
    .sel   (RND_Q24),
    .res   (mul1_res)
  );

  spbaw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dmag + DIV_HALF),
    .res      (div_res)
  );

  // Values computed from the units' results.
  logic signed [MAG_W:0]   mul0_val;
  logic signed [MAG_W:0]   lim_hi;
  logic signed [MAG_W:0]   lim_lo;
  logic signed [ACC_W:0]   quot_val;

  always_comb begin
    mul0_val = signed_mag(mul0_res.neg, mul0_res.mag);
    lim_hi   = (MAG_W + 1)'(out_upper);
    lim_lo   = (MAG_W + 1)'(out_lower);
    quot_val = $signed({1'b0, div_res.quot[ACC_W-1:0]});
    if (dneg) begin
      quot_val = -quot_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      prop_gain     <= 32'd50332;
      integ_gain    <= 32'd83886080;
      backcalc_gain <= 32'd251658;
      out_upper     <= 32'sd393216;
      out_lower     <= -32'sd393216;
      ramp_step     <= 31'd32768;
      integral      <= '0;
      ramp_value    <= '0;
      rev_ticks     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROP_GAIN:     prop_gain     <= cfg_data;
          REG_INTEG_GAIN:    integ_gain    <= cfg_data;
          REG_BACKCALC_GAIN: backcalc_gain <= cfg_data;
          REG_OUT_UPPER:     out_upper     <= cfg_data;
          REG_OUT_LOWER:     out_lower     <= cfg_data;
          REG_RAMP_STEP:     ramp_step     <= cfg_data[30:0];
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            fdb_r      <= fdb_in;
            ramp_value <= ramp_next;
            pen_cnt    <= pen_cnt_next;
            rev_ticks  <= rev_ticks_next;
            pen_sel    <= rev_fwd ? PEN_SUB : (rev_bwd ? PEN_ADD : PEN_NONE);
            state      <= ST_W_REF;
          end
        end
        ST_W_REF: begin
          // The penalty term settles while the first product runs.
          pen_fdb <= pen_val - ACC_W'(fdb_r);
          if (mul0_res.done) begin
            state <= ST_ERR;
          end
        end
        ST_ERR: begin
          err   <= sat48(WIDE_W'(mul0_val) + WIDE_W'(pen_fdb));
          state <= ST_SUM;
        end
        ST_SUM: begin
          state <= ST_W_P;
        end
        ST_W_P: begin
          if (mul0_res.done) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          temp_r     <= mul0_val;
          integ_term <= signed_mag(mul1_res.neg, mul1_res.mag);
          if (mul0_val > lim_hi) begin
            outv        <= out_upper;
            clamp_state <= CLAMP_HIGH;
          end else if (mul0_val < lim_lo) begin
            outv        <= out_lower;
            clamp_state <= CLAMP_LOW;
          end else begin
            outv        <= mul0_val[31:0];
            clamp_state <= CLAMP_NONE;
          end
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          state <= ST_W_B;
        end
        ST_W_B: begin
          if (mul0_res.done) begin
            state <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          delta <= DVD_W'(mul0_val) + DVD_W'(integ_term);
          state <= ST_MAGD;
        end
        ST_MAGD: begin
          dneg  <= delta[DVD_W-1];
          dmag  <= delta[DVD_W-1] ? DVD_W'(-delta) : DVD_W'(delta);
          state <= ST_DIVS;
        end
        ST_DIVS: begin
          state <= ST_W_DIV;
        end
        ST_W_DIV: begin
          if (div_res.done) begin
            state <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          integral <= sat48(WIDE_W'(integral) + WIDE_W'(quot_val));
          state    <= ST_DONE;
        end
        ST_DONE: begin
          // Hand the word to the output register once it is free.
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'd0, rev_ticks, clamp_state, ramp_value, outv};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_one_word: assert property (@(posedge clk) disable iff (rst)
      (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a word is still in work");

  a_mul_done: assert property (@(posedge clk) disable iff (rst)
      mul0_res.done |-> (state == ST_W_REF || state == ST_W_P || state == ST_W_B))
    else $error("multiplier finished outside a wait state");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
      div_res.done |-> (state == ST_W_DIV))
    else $error("divider finished outside its wait state");

  a_rev_clear: assert property (@(posedge clk) disable iff (rst)
      (accept && (fdb_in > CTRL_FDB || fdb_in < -CTRL_FDB)) |=> (rev_ticks == 16'd0))
    else $error("reversal counter not cleared at high feedback speed");
`endif

endmodule
